// File: rtl/nge_pkg.sv
// Shared constants for the noise gate envelope unit.
`default_nettype none
package nge_pkg;

    // Default widths of the audio samples and the smoothing coefficients.
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFFICIENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFFICIENT = 2'd2;

    // Reset values of the configuration registers before truncation to width.
    localparam longint THRESHOLD_RST = 83886;
    localparam longint ATTACK_RST    = 65535;
    localparam longint RELEASE_RST   = 65508;

endpackage : nge_pkg
`default_nettype wire

// File: rtl/noise_gate_envelope_unit.sv
// Noise gate with envelope follower and smoothed gain, one shared multiplier.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one signed audio sample per item in
//   s_tdata[SAMPLE_BITS-1:0]; m_tvalid/m_tready/m_tdata return one gated
//   sample per item in the same layout. Upper pad bits of m_tdata are zero.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the gate threshold (0),
//   attack coefficient (1) and release coefficient (2); other indexes are
//   dropped. cfg_ready is always high; write only while no item is in work.
//   Each item goes through these steps from accept to the next accept:
//   take the sample, form the magnitude, then three multiply-and-add
//   passes (envelope, gain, output), each a multiply and an add step,
//   through the single signed multiplier and its adder. m_tvalid rises
//   on the return to idle. s_tready is high only while the sequencer
//   is idle. The output register lets the next item be taken while a result
//   waits; if the receiver still stalls when the following result is done,
//   the sequencer holds in its last step until m_tready frees the register.
//   Synchronous reset (aresetn low) clears the envelope to zero, sets the
//   gain to unity, loads the register defaults and drops any pending item.
`default_nettype none
module noise_gate_envelope_unit
    import nge_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [SAMPLE_BITS-1:0] sample_in
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [SAMPLE_BITS-1:0] sample_out
    output logic      [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [((SAMPLE_BITS - 1 > COEF_BITS) ? SAMPLE_BITS - 1 : COEF_BITS) - 1:0]
                                        cfg_data
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int GAIN_W = COEF_BITS + 1;
    // Operand A holds envelope differences, gain differences or the sample.
    localparam int OPA_W  = (SAMPLE_BITS + 1 > COEF_BITS + 2) ?
                            SAMPLE_BITS + 1 : COEF_BITS + 2;
    localparam int OPB_W  = COEF_BITS + 2;
    localparam int PROD_W = OPA_W + OPB_W;

    localparam logic [MAG_W-1:0]     MAG_MAX = {MAG_W{1'b1}};
    localparam logic [GAIN_W-1:0]    UNITY   = {1'b1, {COEF_BITS{1'b0}}};
    localparam logic [MAG_W-1:0]     THR_RST = MAG_W'(THRESHOLD_RST);
    localparam logic [COEF_BITS-1:0] ATK_RST = COEF_BITS'(ATTACK_RST);
    localparam logic [COEF_BITS-1:0] REL_RST = COEF_BITS'(RELEASE_RST);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_ENV_MUL,
        ST_ENV_ADD,
        ST_GAIN_MUL,
        ST_GAIN_ADD,
        ST_OUT_MUL,
        ST_OUT_ADD
    } state_t;

    state_t                     state_reg, state_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0]     m_data_reg, m_data_next;

    logic [MAG_W-1:0]           thr_reg, thr_next;
    logic [COEF_BITS-1:0]       atk_reg, atk_next;
    logic [COEF_BITS-1:0]       rel_reg, rel_next;

    logic [MAG_W-1:0]           env_reg, env_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;

    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic signed [OPA_W-1:0]    op_a_reg, op_a_next;
    logic [COEF_BITS:0]         op_b_reg, op_b_next;
    logic signed [OPA_W-1:0]    base_reg, base_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    // Datapath helpers
    logic [SAMPLE_BITS-1:0]     mag_full;
    logic [MAG_W-1:0]           mag;
    logic signed [PROD_W-1:0]   blend_sum;
    logic [MAG_W-1:0]           env_new;
    logic [GAIN_W-1:0]          gain_new;
    logic                       gate_open;
    logic [GAIN_W-1:0]          target;
    logic                       out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = DATA_W'(m_data_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Magnitude, saturating the most negative sample.
    assign mag_full = sample_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample_reg + 1'b1)
                                                : SAMPLE_BITS'(sample_reg);
    assign mag      = mag_full[SAMPLE_BITS-1] ? MAG_MAX : mag_full[MAG_W-1:0];

    // Shared multiply result: base + floor(product / 2^COEF_BITS).
    assign blend_sum = PROD_W'(base_reg) + (prod_reg >>> COEF_BITS);
    assign env_new   = blend_sum[MAG_W-1:0];
    assign gain_new  = blend_sum[GAIN_W-1:0];
    assign gate_open = (env_new > thr_reg);
    assign target    = gate_open ? UNITY : '0;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        thr_next      = thr_reg;
        atk_next      = atk_reg;
        rel_next      = rel_reg;
        env_next      = env_reg;
        gain_next     = gain_reg;
        sample_next   = sample_reg;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        base_next     = base_reg;
        prod_next     = PROD_W'(op_a_reg) * PROD_W'($signed({1'b0, op_b_reg}));

        // Drop the result once the receiver takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GATE_THRESHOLD:      thr_next = cfg_data[MAG_W-1:0];
                REG_ATTACK_COEFFICIENT:  atk_next = cfg_data[COEF_BITS-1:0];
                REG_RELEASE_COEFFICIENT: rel_next = cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                    state_next  = ST_MAG;
                end
            end
            ST_MAG: begin
                // Envelope blend: mag + floor(c * (env - mag) / 2^COEF_BITS).
                op_a_next  = OPA_W'($signed({2'b00, env_reg} - {2'b00, mag}));
                op_b_next  = (mag > env_reg) ? {1'b0, atk_reg} : {1'b0, rel_reg};
                base_next  = OPA_W'($signed({1'b0, mag}));
                state_next = ST_ENV_MUL;
            end
            ST_ENV_MUL: begin
                state_next = ST_ENV_ADD;
            end
            ST_ENV_ADD: begin
                env_next   = env_new;
                // Gain blend toward the gate target, attack only when rising.
                op_a_next  = $signed(OPA_W'(gain_reg)) - $signed(OPA_W'(target));
                op_b_next  = (gate_open && (gain_reg != UNITY)) ? {1'b0, atk_reg}
                                                                : {1'b0, rel_reg};
                base_next  = $signed(OPA_W'(target));
                state_next = ST_GAIN_MUL;
            end
            ST_GAIN_MUL: begin
                state_next = ST_GAIN_ADD;
            end
            ST_GAIN_ADD: begin
                gain_next  = gain_new;
                op_a_next  = OPA_W'(sample_reg);
                op_b_next  = gain_new;
                base_next  = '0;
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL: begin
                state_next = ST_OUT_ADD;
            end
            ST_OUT_ADD: begin
                // Hold until the output register is free.
                if (out_free) begin
                    m_data_next   = blend_sum[SAMPLE_BITS-1:0];
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        base_reg   <= base_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            thr_reg      <= THR_RST;
            atk_reg      <= ATK_RST;
            rel_reg      <= REL_RST;
            env_reg      <= '0;
            gain_reg     <= UNITY;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            thr_reg      <= thr_next;
            atk_reg      <= atk_next;
            rel_reg      <= rel_next;
            env_reg      <= env_next;
            gain_reg     <= gain_next;
        end
    end

endmodule : noise_gate_envelope_unit
`default_nettype wire

// File: rtl/nge_chk.sv
// Port-level checker for the noise gate envelope unit, with its bind.
`default_nettype none
module nge_chk #(
    parameter int DATA_W = 24
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [DATA_W-1:0] m_tdata
);

    // One item at a time: ready drops right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // Reset drops any pending result.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A fresh result comes as the sequencer returns to idle.
    a_done_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while sequencer still busy");

endmodule : nge_chk

bind noise_gate_envelope_unit nge_chk #(
    .DATA_W (((SAMPLE_BITS + 7) / 8) * 8)
) u_nge_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
